/* rtl/abi_pkg.sv */
package abi_pkg;

	localparam int ITERATIONS_DEF = 30;
	localparam int FRAC_BITS_DEF  = 40;
	localparam logic [31:0] ANGLE_MAX = 32'd1686629713;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQRT0,
		ST_DIV0,
		ST_AVG,
		ST_MUL,
		ST_SQRT,
		ST_FMUL,
		ST_DIV1,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SQRT0,
		CMD_DIV0,
		CMD_AVG,
		CMD_MUL,
		CMD_FMUL,
		CMD_DIV1
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    start;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

endpackage

/* rtl/abi_ctrl.sv */
module abi_ctrl import abi_pkg::*; #(
	parameter int ITERATIONS = ITERATIONS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output cmd_t  cmd,
	input  stat_t stat
);

	localparam int CW = $clog2(ITERATIONS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic started_q, started_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			started_q <= started_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		started_d = started_q;
		cmd.op    = CMD_NONE;
		cmd.start = 1'b0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = CMD_LOAD;
					cmd.start = 1'b1;
					state_d   = ST_SQRT0;
					started_d = 1'b0;
					cnt_d     = '0;
				end
			end
			ST_SQRT0, ST_DIV0, ST_SQRT, ST_FMUL, ST_DIV1: begin
				case (state_q)
					ST_SQRT0: cmd.op = CMD_SQRT0;
					ST_DIV0:  cmd.op = CMD_DIV0;
					ST_SQRT:  cmd.op = CMD_MUL;
					ST_FMUL:  cmd.op = CMD_FMUL;
					default:  cmd.op = CMD_DIV1;
				endcase
				if (!started_q) begin
					cmd.start = 1'b1;
					started_d = 1'b1;
				end else if (stat.done) begin
					started_d = 1'b0;
					unique case (state_q)
						ST_SQRT0: state_d = ST_DIV0;
						ST_DIV0:  state_d = (ITERATIONS > 0) ? ST_AVG : ST_FMUL;
						ST_SQRT: begin
							cnt_d   = cnt_q + 1'b1;
							state_d = (cnt_q == CW'(ITERATIONS - 1)) ? ST_FMUL : ST_AVG;
						end
						ST_FMUL:  state_d = ST_DIV1;
						default:  state_d = ST_OUT;
					endcase
				end
			end
			ST_AVG: begin
				cmd.op    = CMD_AVG;
				cmd.start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.op    = CMD_MUL;
				cmd.start = 1'b1;
				state_d   = ST_SQRT;
				started_d = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready and valid together");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !stat.busy)
		else $error("datapath busy in idle");

endmodule

/* rtl/abi_dp.sv */
module abi_dp import abi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] x_value,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic [31:0] angle
);

	localparam logic [127:0] DIV0_NUM = 128'd1 << (FRAC_BITS + 48);
	localparam logic [63:0]  ONE_Q    = 64'd1 << FRAC_BITS;
	localparam logic [63:0]  X2_ONE   = 64'h1_0000_0000;

	cmd_op_t      op_q;
	logic         neg_q;
	logic [31:0]  m_q;
	logic [63:0]  a0_q, a_q, b_q;
	// 64x64 multiplier, one 32x32 partial product per cycle
	logic         mrun_q;
	logic [1:0]   mstep_q;
	logic [63:0]  ma_q, mb_q;
	logic [127:0] prod_q;
	// shared bit-serial unit: root takes 2 operand bits per step, divide takes 1
	logic         run_q;
	logic         div_q;
	logic [5:0]   step_q;
	logic [127:0] sh_q;
	logic [64:0]  rem_q;
	logic [63:0]  res_q;
	logic [63:0]  d_q;
	logic         sat_q;
	logic         done_q;

	logic [31:0]  mpa, mpb;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [127:0] prod_nx;
	logic [66:0]  sq_cur, sq_trial, sq_diff;
	logic         sq_take;
	logic [64:0]  dv_cur, dv_diff;
	logic         dv_take;
	logic [64:0]  rem_nx;
	logic [63:0]  res_nx;
	logic [127:0] dnum;
	logic [63:0]  dden_raw, dden;
	logic [64:0]  avg_sum;
	logic [63:0]  qv;
	logic [31:0]  mag;

	assign mpa = mstep_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mpb = mstep_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp  = 64'(mpa) * 64'(mpb);

	always_comb begin
		case (mstep_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end
	assign prod_nx = prod_q + pp_sh;

	assign sq_cur   = {rem_q, sh_q[127:126]};
	assign sq_trial = {1'b0, res_q, 2'b01};
	assign sq_take  = sq_cur >= sq_trial;
	assign sq_diff  = sq_cur - sq_trial;

	assign dv_cur  = {rem_q[63:0], sh_q[127]};
	assign dv_take = dv_cur >= {1'b0, d_q};
	assign dv_diff = dv_cur - {1'b0, d_q};

	always_comb begin
		if (div_q) begin
			rem_nx = dv_take ? dv_diff : dv_cur;
			res_nx = {res_q[62:0], dv_take};
		end else begin
			rem_nx = 65'(sq_take ? sq_diff : sq_cur);
			res_nx = {res_q[62:0], sq_take};
		end
	end

	assign dnum     = (cmd.op == CMD_DIV0) ? DIV0_NUM : (prod_q << 14);
	assign dden_raw = (cmd.op == CMD_DIV0) ? res_q : a_q;
	assign dden     = (dden_raw == 64'd0) ? 64'd1 : dden_raw;
	assign avg_sum  = {1'b0, a_q} + {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= CMD_NONE;
			neg_q   <= 1'b0;
			m_q     <= '0;
			a0_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			mrun_q  <= 1'b0;
			mstep_q <= '0;
			ma_q    <= '0;
			mb_q    <= '0;
			prod_q  <= '0;
			run_q   <= 1'b0;
			div_q   <= 1'b0;
			step_q  <= '0;
			sh_q    <= '0;
			rem_q   <= '0;
			res_q   <= '0;
			d_q     <= '0;
			sat_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q <= cmd.op;
				unique case (cmd.op)
					CMD_LOAD: begin
						neg_q <= x_value[31];
						m_q   <= x_value[31] ? 32'd0 - x_value : x_value;
					end
					CMD_SQRT0, CMD_FMUL: begin
						ma_q    <= {32'd0, m_q};
						mb_q    <= (cmd.op == CMD_FMUL) ? a0_q : {32'd0, m_q};
						mstep_q <= '0;
						prod_q  <= '0;
						mrun_q  <= 1'b1;
					end
					CMD_MUL: begin
						ma_q    <= a_q;
						mb_q    <= b_q;
						mstep_q <= '0;
						prod_q  <= '0;
						mrun_q  <= 1'b1;
					end
					CMD_AVG: a_q <= avg_sum[64:1];
					CMD_DIV0, CMD_DIV1: begin
						sh_q   <= {dnum[63:0], 64'd0};
						rem_q  <= {1'b0, dnum[127:64]};
						d_q    <= dden;
						sat_q  <= dnum[127:64] >= dden;
						res_q  <= '0;
						step_q <= 6'd63;
						div_q  <= 1'b1;
						run_q  <= 1'b1;
					end
					default: ;
				endcase
			end else if (mrun_q) begin
				prod_q  <= prod_nx;
				mstep_q <= mstep_q + 2'd1;
				if (mstep_q == 2'd3) begin
					mrun_q <= 1'b0;
					if (op_q == CMD_FMUL) begin
						done_q <= 1'b1;
					end else begin
						// hand the product to the root unit
						sh_q   <= (op_q == CMD_SQRT0) ?
							{prod_nx[63:0] + X2_ONE, 64'd0} : prod_nx;
						rem_q  <= '0;
						res_q  <= '0;
						step_q <= 6'd63;
						div_q  <= 1'b0;
						run_q  <= 1'b1;
					end
				end
			end else if (run_q) begin
				sh_q   <= div_q ? {sh_q[126:0], 1'b0} : {sh_q[125:0], 2'b00};
				rem_q  <= rem_nx;
				res_q  <= res_nx;
				step_q <= step_q - 6'd1;
				if (step_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
					case (op_q)
						CMD_DIV0: begin
							a0_q <= sat_q ? '1 : res_nx;
							a_q  <= sat_q ? '1 : res_nx;
							b_q  <= ONE_Q;
						end
						CMD_MUL: b_q <= res_nx;
						default: ;
					endcase
				end
			end
		end
	end

	assign stat = '{busy: run_q | mrun_q, done: done_q};

	assign qv    = sat_q ? 64'hFFFF_FFFF_FFFF_FFFF : res_q;
	assign mag   = (qv > {32'd0, ANGLE_MAX}) ? ANGLE_MAX : qv[31:0];
	assign angle = neg_q ? (32'd0 - mag) : mag;

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_q && mrun_q))
		else $error("units overlap");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !run_q && !mrun_q)
		else $error("command while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done not a pulse");

endmodule

/* rtl/arctan_borchardt_iteration.sv */
// Sequence from input accept to m_tvalid: the first root (multiply, then root), a divide,
// ITERATIONS rounds of average, multiply and root, then the final multiply and divide.
// Uses the multiplier (four 32x32 partials) and the 64-step bit-serial root and divide units.
// Throughput: one transaction at a time; a new input is accepted only after the result is taken.
// Reset: arst_n asynchronous, active low, returns the controller to idle.
module arctan_borchardt_iteration import abi_pkg::*; #(
	parameter int ITERATIONS = ITERATIONS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] x_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] angle
);

	cmd_t  cmd;
	stat_t stat;

	abi_ctrl #(.ITERATIONS(ITERATIONS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd, .stat
	);

	abi_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n,
		.x_value(s_tdata), .cmd, .stat, .angle(m_tdata)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import abi_pkg::*;

	localparam int ROUNDS = ITERATIONS_DEF;
	localparam int FB     = FRAC_BITS_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	logic [31:0] angle_q[$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	arctan_borchardt_iteration uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] isqrt128(input logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] sq;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (64'd1 << i);
			sq = {64'd0, t} * {64'd0, t};
			if (sq <= n)
				r = t;
		end
		return r;
	endfunction

	// floor(n/d), saturating when the quotient exceeds 64 bits
	function automatic logic [63:0] udiv_sat(input logic [127:0] n, input logic [63:0] d);
		logic [127:0] q;
		if (d == 0)
			d = 64'd1;
		q = n / {64'd0, d};
		if (q[127:64] != 0)
			return '1;
		return q[63:0];
	endfunction

	function automatic logic [31:0] arctan_q230(input logic [31:0] x);
		logic         neg;
		logic [63:0]  m;
		logic [63:0]  s_q48;
		logic [63:0]  a0;
		logic [63:0]  a;
		logic [63:0]  b;
		logic [63:0]  mag;
		logic [127:0] w;
		neg = x[31];
		m = neg ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
		w = {(m * m + (64'd1 << 32)), 64'd0};
		s_q48 = isqrt128(w);
		a0 = udiv_sat(128'd1 << (FB + 48), s_q48);
		a = a0;
		b = 64'd1 << FB;
		for (int i = 0; i < ROUNDS; i++) begin
			a = (a + b) >> 1;
			b = isqrt128({64'd0, a} * {64'd0, b});
		end
		w = ({64'd0, m} * {64'd0, a0}) << 14;
		mag = udiv_sat(w, a);
		if (mag > {32'd0, ANGLE_MAX})
			mag = {32'd0, ANGLE_MAX};
		return neg ? 32'd0 - mag[31:0] : mag[31:0];
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angle_q.size() == 0) begin
				$display("%0t: unexpected angle %h", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== angle_q[0]) begin
					$display("%0t: angle mismatch: expected %h actual %h",
						$time, angle_q[0], m_tdata);
					errors++;
				end
				void'(angle_q.pop_front());
			end
		end
	end

	task automatic idle_gap(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_x(input logic [31:0] x);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			idle_gap($urandom_range(1, 8));
		s_tvalid <= 1'b1;
		s_tdata <= x;
		do @(posedge clk); while (!s_tready);
		angle_q.push_back(arctan_q230(x));
	endtask

	task automatic drain;
		idle_gap(1);
		while (angle_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_x;
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(3))
			0: v = $signed(v) >>> $urandom_range(31);
			1: v = v >> $urandom_range(31);
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_directed;
		logic [31:0] vals[$];
		vals = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_8000, 32'h0002_0000, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h0100_0000, 32'hFF00_0000, 32'h0000_0100, 32'h4000_0000,
			32'hC000_0000, 32'h0003_243F};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (vals[i]) send_x(vals[i]);
		drain();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_x(rand_x());
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 120);
		test_random(46, 0, 120);
		test_random(0, 46, 120);
		test_random(37, 37, 120);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#200ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
